/* src/depth_sigma_normalizer_assert.svh */
// Assertion macros used by the checker of the depth normalizer.
`ifndef DEPTH_SIGMA_NORMALIZER_ASSERT_SVH
`define DEPTH_SIGMA_NORMALIZER_ASSERT_SVH

// Consequent in the cycle after the antecedent, checked outside reset.
`define DSN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("depth normalizer check failed");

// Consequent in the cycle after the antecedent, checked at every edge.
`define DSN_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("depth normalizer check failed");

`endif

/* src/dsn_pkg.sv */
// ----------------------------------------------------------------------------
// dsn_pkg
// Types, codes and constants shared by the depth sigma normalizer modules.
// ----------------------------------------------------------------------------
package dsn_pkg;

    localparam int DEF_MAX_PIXELS_LOG2 = 22;
    localparam int DEF_FRACTION_BITS   = 24;

    localparam logic FUNC_ACC = 1'b0;
    localparam logic FUNC_MAP = 1'b1;

    localparam logic [31:0] ONE_BITS = 32'h3F80_0000;

    localparam int DIV_N_W = 64;
    localparam int DIV_D_W = 32;
    localparam int SQRT_W  = 24;

    localparam logic [DIV_N_W-1:0] SCALE_NUM = DIV_N_W'(255) << 40;
    localparam logic [31:0]        SCALE_SAT = 32'hFFFF_FFFF;

    localparam logic [7:0] GREY_MIN = 8'd0;
    localparam logic [7:0] GREY_MID = 8'd128;
    localparam logic [7:0] GREY_MAX = 8'd255;

    localparam int FQ_DEPTH = 4;
    localparam int OQ_DEPTH = 4;

    typedef enum logic [1:0] {
        CLS_ZERO,
        CLS_ONE,
        CLS_VALID
    } t_class;

    typedef struct packed {
        logic   func;
        t_class cls;
        logic   last;
    } t_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_STATS,
        ST_DIV_MEAN,
        ST_DIV_MSQ,
        ST_MEANSQ,
        ST_VAR,
        ST_SQRT,
        ST_SIGMA,
        ST_DIV_SCALE
    } t_state;

endpackage

/* src/dsn_front.sv */
// ----------------------------------------------------------------------------
// dsn_front
// Accepts depth samples, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module dsn_front
    import dsn_pkg::*;
#(
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    output logic                     o_full,
    input  logic                     i_func,
    input  logic [31:0]              i_depth_bits,
    input  logic                     i_last,
    output logic                     o_item_valid,
    output t_item                    o_item,
    output logic [FRACTION_BITS-1:0] o_q,
    input  logic                     i_take
);

    localparam int PTR_W   = $clog2(FQ_DEPTH);
    localparam int CNT_W   = PTR_W + 1;
    localparam int SH_BASE = 150 - FRACTION_BITS;

    t_item                    r_item [FQ_DEPTH];
    logic [FRACTION_BITS-1:0] r_q    [FQ_DEPTH];
    logic [PTR_W-1:0]         r_wr;
    logic [PTR_W-1:0]         r_rd;
    logic [CNT_W-1:0]         r_cnt;

    logic                     wr_en;
    logic                     rd_en;
    t_item                    cls_item;
    logic [FRACTION_BITS-1:0] cls_q;
    logic [7:0]               expo;
    logic [9:0]               sh;
    logic [23:0]              shifted;

    always_comb begin
        expo    = i_depth_bits[30:23];
        sh      = 10'(SH_BASE) - {2'b00, expo};
        shifted = {1'b1, i_depth_bits[22:0]} >> sh[4:0];
        // Subnormals and samples far below one LSB still count, with value zero.
        if (expo == 8'd0 || sh >= 10'd32) begin
            cls_q = '0;
        end else begin
            cls_q = shifted[FRACTION_BITS-1:0];
        end
        cls_item.func = i_func;
        cls_item.last = i_last;
        if (i_depth_bits == ONE_BITS) begin
            cls_item.cls = CLS_ONE;
        end else if (i_depth_bits != 32'd0 && i_depth_bits < ONE_BITS) begin
            cls_item.cls = CLS_VALID;
        end else begin
            cls_item.cls = CLS_ZERO;
        end
    end

    assign o_full       = (r_cnt == CNT_W'(FQ_DEPTH));
    assign wr_en        = i_push && !o_full;
    assign o_item_valid = (r_cnt != '0);
    assign rd_en        = i_take && o_item_valid;
    assign o_item       = r_item[r_rd];
    assign o_q          = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_item[r_wr] <= cls_item;
            r_q[r_wr]    <= cls_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wr <= r_wr + PTR_W'(1);
            end
            if (rd_en) begin
                r_rd <= r_rd + PTR_W'(1);
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

/* src/dsn_div.sv */
// ----------------------------------------------------------------------------
// dsn_div
// Restoring divider, one quotient bit per cycle, shared by the statistics.
// ----------------------------------------------------------------------------
module dsn_div
    import dsn_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DIV_N_W-1:0] i_dividend,
    input  logic [DIV_D_W-1:0] i_divisor,
    output logic               o_done,
    output logic [DIV_N_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DIV_N_W);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [DIV_N_W-1:0] r_quo;
    logic [DIV_D_W-1:0] r_rem;
    logic [DIV_D_W-1:0] r_dsr;

    logic [DIV_D_W:0]   rem_sh;
    logic [DIV_D_W:0]   rem_sub;

    always_comb begin
        rem_sh  = {r_rem, r_quo[DIV_N_W-1]};
        rem_sub = rem_sh - {1'b0, r_dsr};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_N_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            if (!rem_sub[DIV_D_W]) begin
                r_rem <= rem_sub[DIV_D_W-1:0];
                r_quo <= {r_quo[DIV_N_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[DIV_D_W-1:0];
                r_quo <= {r_quo[DIV_N_W-2:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* src/dsn_back.sv */
// ----------------------------------------------------------------------------
// dsn_back
// Accumulates frame statistics, derives mean and scale, maps samples to grey.
// ----------------------------------------------------------------------------
module dsn_back
    import dsn_pkg::*;
#(
    parameter int MAX_PIXELS_LOG2 = DEF_MAX_PIXELS_LOG2,
    parameter int FRACTION_BITS   = DEF_FRACTION_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_item_valid,
    input  t_item                    i_item,
    input  logic [FRACTION_BITS-1:0] i_q,
    output logic                     o_take,
    output logic                     o_div_start,
    output logic [DIV_N_W-1:0]       o_div_dividend,
    output logic [DIV_D_W-1:0]       o_div_divisor,
    input  logic                     i_div_done,
    input  logic [DIV_N_W-1:0]       i_div_quotient,
    input  logic                     i_pop,
    output logic                     o_empty,
    output logic [7:0]               o_grey,
    output logic                     o_last_out
);

    localparam int FB      = FRACTION_BITS;
    localparam int CNT_W   = MAX_PIXELS_LOG2 + 1;
    localparam int SV_W    = FB + MAX_PIXELS_LOG2;
    localparam int SS_W    = 32 + MAX_PIXELS_LOG2;
    localparam int PROD_W  = FB + 34;
    localparam int ACC_W   = FB + 35;
    localparam int HI_W    = ACC_W - 1 - (FB + 16);
    localparam int SQ_RSH  = (2 * FB >= 32) ? 2 * FB - 32 : 0;
    localparam int SQ_LSH  = (2 * FB >= 32) ? 0 : 32 - 2 * FB;
    localparam int RAD_W   = 2 * SQRT_W;
    localparam int REM_W   = SQRT_W + 2;
    localparam int SQC_W   = $clog2(SQRT_W);
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = OQ_PTR_W + 1;

    localparam logic [CNT_W-1:0] CAP = {1'b1, {MAX_PIXELS_LOG2{1'b0}}};
    localparam logic signed [ACC_W-1:0] BIAS = ACC_W'(255) <<< (FB + 15);

    t_state r_state;
    t_state n_state;

    logic [SV_W-1:0]  r_sum_v;
    logic [SS_W-1:0]  r_sum_s;
    logic [CNT_W-1:0] r_count;
    logic [FB-1:0]    r_mean;
    logic [31:0]      r_scale;
    logic             r_flat;
    logic [31:0]      r_msq;
    logic [31:0]      r_meansq;
    logic [RAD_W-1:0] r_rad;
    logic [REM_W-1:0] r_rem;
    logic [SQRT_W-1:0] r_root;
    logic [SQC_W-1:0] r_sq_cnt;

    logic                     r_mp_valid;
    logic                     r_mp_calc;
    logic [7:0]               r_mp_grey;
    logic                     r_mp_last;
    logic signed [PROD_W-1:0] r_prod;

    logic [7:0]          r_oq_grey [OQ_DEPTH];
    logic                r_oq_last [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] r_oq_wr;
    logic [OQ_PTR_W-1:0] r_oq_rd;
    logic [OQ_CNT_W-1:0] r_oq_cnt;

    logic                     take_acc;
    logic                     take_map;
    logic [2*FB-1:0]          q_sq;
    logic [31:0]              q_sq32;
    logic [2*FB-1:0]          m_sq;
    logic [31:0]              m_sq32;
    logic signed [FB:0]       diff;
    logic signed [PROD_W-1:0] prod;
    logic [7:0]               fixed_grey;
    logic signed [ACC_W-1:0]  acc;
    logic [HI_W-1:0]          acc_hi;
    logic [7:0]               calc_grey;
    logic [7:0]               push_grey;
    logic                     oq_push;
    logic                     oq_pop;
    logic [31:0]              var_v;
    logic [REM_W+1:0]         rem_sh;
    logic [REM_W+1:0]         trial;
    logic [31:0]              scale_sat;

    // Front-end handshake, divider requests and the next-state logic of the sequencer.
    always_comb begin
        n_state        = r_state;
        o_take         = 1'b0;
        o_div_start    = 1'b0;
        o_div_dividend = '0;
        o_div_divisor  = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_item_valid) begin
                    if (i_item.func == FUNC_ACC) begin
                        o_take = 1'b1;
                        if (i_item.last) begin
                            n_state = ST_STATS;
                        end
                    end else if ((r_oq_cnt + OQ_CNT_W'(r_mp_valid)) < OQ_CNT_W'(OQ_DEPTH))
                    begin
                        o_take = 1'b1;
                    end
                end
            end
            ST_STATS: begin
                if (r_count == '0) begin
                    n_state = ST_IDLE;
                end else begin
                    o_div_start    = 1'b1;
                    o_div_dividend = DIV_N_W'(r_sum_v);
                    o_div_divisor  = DIV_D_W'(r_count);
                    n_state        = ST_DIV_MEAN;
                end
            end
            ST_DIV_MEAN: begin
                if (i_div_done) begin
                    o_div_start    = 1'b1;
                    o_div_dividend = DIV_N_W'(r_sum_s);
                    o_div_divisor  = DIV_D_W'(r_count);
                    n_state        = ST_DIV_MSQ;
                end
            end
            ST_DIV_MSQ: begin
                if (i_div_done) begin
                    n_state = ST_MEANSQ;
                end
            end
            ST_MEANSQ: begin
                n_state = ST_VAR;
            end
            ST_VAR: begin
                n_state = ST_SQRT;
            end
            ST_SQRT: begin
                if (r_sq_cnt == SQC_W'(SQRT_W - 1)) begin
                    n_state = ST_SIGMA;
                end
            end
            ST_SIGMA: begin
                if (r_root == '0) begin
                    n_state = ST_IDLE;
                end else begin
                    o_div_start    = 1'b1;
                    o_div_dividend = SCALE_NUM;
                    o_div_divisor  = DIV_D_W'({2'b00, r_root} + {1'b0, r_root, 1'b0});
                    n_state        = ST_DIV_SCALE;
                end
            end
            ST_DIV_SCALE: begin
                if (i_div_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        take_acc = o_take && (i_item.func == FUNC_ACC);
        take_map = o_take && (i_item.func == FUNC_MAP);

        // Squares are brought to Q0.32 whatever the fraction width.
        q_sq   = i_q * i_q;
        q_sq32 = 32'((64'(q_sq) << SQ_LSH) >> SQ_RSH);
        m_sq   = r_mean * r_mean;
        m_sq32 = 32'((64'(m_sq) << SQ_LSH) >> SQ_RSH);
        var_v  = (r_msq > r_meansq) ? (r_msq - r_meansq) : 32'd0;

        diff = $signed({1'b0, i_q}) - $signed({1'b0, r_mean});
        prod = diff * $signed({1'b0, r_scale});

        case (i_item.cls)
            CLS_ONE:   fixed_grey = GREY_MAX;
            CLS_VALID: fixed_grey = r_flat ? GREY_MID : GREY_MIN;
            default:   fixed_grey = GREY_MIN;
        endcase

        acc    = ACC_W'(r_prod) + BIAS;
        acc_hi = acc[ACC_W-2:FB+16];
        if (acc[ACC_W-1]) begin
            calc_grey = GREY_MIN;
        end else if (acc_hi > HI_W'(255)) begin
            calc_grey = GREY_MAX;
        end else begin
            calc_grey = acc_hi[7:0];
        end
        push_grey = r_mp_calc ? calc_grey : r_mp_grey;

        rem_sh = {r_rem, r_rad[RAD_W-1 -: 2]};
        trial  = (REM_W+2)'({r_root, 2'b01});

        scale_sat = (i_div_quotient[DIV_N_W-1:32] != '0) ? SCALE_SAT : i_div_quotient[31:0];

        oq_push = r_mp_valid;
        oq_pop  = i_pop && !o_empty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_v    <= '0;
            r_sum_s    <= '0;
            r_count    <= '0;
            r_mean     <= '0;
            r_scale    <= '0;
            r_flat     <= 1'b1;
            r_mp_valid <= 1'b0;
        end else begin
            r_mp_valid <= take_map;
            case (r_state)
                ST_IDLE: begin
                    if (take_acc && i_item.cls == CLS_VALID && r_count < CAP) begin
                        r_sum_v <= r_sum_v + SV_W'(i_q);
                        r_sum_s <= r_sum_s + SS_W'(q_sq32);
                        r_count <= r_count + CNT_W'(1);
                    end
                    if (take_map && i_item.last) begin
                        r_sum_v <= '0;
                        r_sum_s <= '0;
                        r_count <= '0;
                    end
                end
                ST_STATS: begin
                    if (r_count == '0) begin
                        r_mean  <= '0;
                        r_scale <= '0;
                        r_flat  <= 1'b1;
                    end
                end
                ST_DIV_MEAN: begin
                    if (i_div_done) begin
                        r_mean <= i_div_quotient[FB-1:0];
                    end
                end
                ST_SIGMA: begin
                    if (r_root == '0) begin
                        r_mean  <= '0;
                        r_scale <= '0;
                        r_flat  <= 1'b1;
                    end
                end
                ST_DIV_SCALE: begin
                    if (i_div_done) begin
                        r_scale <= scale_sat;
                        r_flat  <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Working registers of the statistics pass and the map pipeline stage.
    always_ff @(posedge i_clk) begin
        if (take_map) begin
            r_mp_calc <= (i_item.cls == CLS_VALID) && !r_flat;
            r_mp_grey <= fixed_grey;
            r_mp_last <= i_item.last;
            r_prod    <= prod;
        end
        if (r_state == ST_DIV_MSQ && i_div_done) begin
            r_msq <= i_div_quotient[31:0];
        end
        if (r_state == ST_MEANSQ) begin
            r_meansq <= m_sq32;
        end
        if (r_state == ST_VAR) begin
            r_rad    <= {var_v, 16'h0000};
            r_rem    <= '0;
            r_root   <= '0;
            r_sq_cnt <= '0;
        end
        // One root bit per cycle: two radicand bits are brought down each step.
        if (r_state == ST_SQRT) begin
            r_rad    <= {r_rad[RAD_W-3:0], 2'b00};
            r_sq_cnt <= r_sq_cnt + SQC_W'(1);
            if (rem_sh >= trial) begin
                r_rem  <= REM_W'(rem_sh - trial);
                r_root <= {r_root[SQRT_W-2:0], 1'b1};
            end else begin
                r_rem  <= REM_W'(rem_sh);
                r_root <= {r_root[SQRT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (oq_push) begin
            r_oq_grey[r_oq_wr] <= push_grey;
            r_oq_last[r_oq_wr] <= r_mp_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wr  <= '0;
            r_oq_rd  <= '0;
            r_oq_cnt <= '0;
        end else begin
            if (oq_push) begin
                r_oq_wr <= r_oq_wr + OQ_PTR_W'(1);
            end
            if (oq_pop) begin
                r_oq_rd <= r_oq_rd + OQ_PTR_W'(1);
            end
            if (oq_push && !oq_pop) begin
                r_oq_cnt <= r_oq_cnt + OQ_CNT_W'(1);
            end else if (oq_pop && !oq_push) begin
                r_oq_cnt <= r_oq_cnt - OQ_CNT_W'(1);
            end
        end
    end

    assign o_empty    = (r_oq_cnt == '0);
    assign o_grey     = r_oq_grey[r_oq_rd];
    assign o_last_out = r_oq_last[r_oq_rd];

endmodule

/* src/depth_sigma_normalizer.sv */
// ----------------------------------------------------------------------------
// depth_sigma_normalizer
// Maps float32 depth samples to 8-bit grey through a 3-sigma window.
// ----------------------------------------------------------------------------
// Input: write a beat with i_push while o_full is low; i_func selects the
// accumulate pass (0) or the map pass (1), i_last marks the frame's end.
// Output: while o_empty is low, o_grey and o_last_out show the oldest grey
// value; i_pop takes it. Only map beats produce output.
// Beats are taken one per cycle while the sequencer is idle, map beats only
// while the output queue has room. Map beats pass the map stage register.
// The accumulate beat marked last starts the statistics sequencer, which
// holds the input for up to three divisions in the shared one-bit-per-cycle
// divider and a 24-step square root.
// When the receiver stalls, the four-entry output queue fills and then the
// four-entry input queue; o_full rises once both are full.
// Reset empties both queues, clears the sums, mean and scale and marks the
// frame flat, so valid samples map to 128 until statistics are taken.
// ----------------------------------------------------------------------------
module depth_sigma_normalizer
    import dsn_pkg::*;
#(
    parameter int MAX_PIXELS_LOG2 = DEF_MAX_PIXELS_LOG2,
    parameter int FRACTION_BITS   = DEF_FRACTION_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic        i_func,
    input  logic [31:0] i_depth_bits,
    input  logic        i_last,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [7:0]  o_grey,
    output logic        o_last_out
);

    logic                     item_valid;
    t_item                    item;
    logic [FRACTION_BITS-1:0] item_q;
    logic                     take;
    logic                     div_start;
    logic [DIV_N_W-1:0]       div_dividend;
    logic [DIV_D_W-1:0]       div_divisor;
    logic                     div_done;
    logic [DIV_N_W-1:0]       div_quotient;

    dsn_front #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .o_full      (o_full),
        .i_func      (i_func),
        .i_depth_bits(i_depth_bits),
        .i_last      (i_last),
        .o_item_valid(item_valid),
        .o_item      (item),
        .o_q         (item_q),
        .i_take      (take)
    );

    dsn_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_dividend(div_dividend),
        .i_divisor (div_divisor),
        .o_done    (div_done),
        .o_quotient(div_quotient)
    );

    dsn_back #(
        .MAX_PIXELS_LOG2(MAX_PIXELS_LOG2),
        .FRACTION_BITS  (FRACTION_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item_valid  (item_valid),
        .i_item        (item),
        .i_q           (item_q),
        .o_take        (take),
        .o_div_start   (div_start),
        .o_div_dividend(div_dividend),
        .o_div_divisor (div_divisor),
        .i_div_done    (div_done),
        .i_div_quotient(div_quotient),
        .i_pop         (i_pop),
        .o_empty       (o_empty),
        .o_grey        (o_grey),
        .o_last_out    (o_last_out)
    );

endmodule

/* src/dsn_checker.sv */
// ----------------------------------------------------------------------------
// dsn_checker
// Port-level checks on the depth normalizer, bound to its top level.
// ----------------------------------------------------------------------------
`include "depth_sigma_normalizer_assert.svh"

module dsn_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_full,
    input logic       o_empty,
    input logic       i_pop,
    input logic [7:0] o_grey,
    input logic       o_last_out
);

    // Reset leaves both queues empty.
    `DSN_ASSERT_NEXT_ALWAYS(a_rst_empty, i_clk, !i_rst_n, o_empty)
    `DSN_ASSERT_NEXT_ALWAYS(a_rst_not_full, i_clk, !i_rst_n, !o_full)
    // A waiting grey beat holds until it is popped.
    `DSN_ASSERT_NEXT(a_hold_grey, i_clk, i_rst_n, !o_empty && !i_pop, $stable(o_grey))
    `DSN_ASSERT_NEXT(a_hold_last, i_clk, i_rst_n, !o_empty && !i_pop, $stable(o_last_out))

endmodule

bind depth_sigma_normalizer dsn_checker u_dsn_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .o_full    (o_full),
    .o_empty   (o_empty),
    .i_pop     (i_pop),
    .o_grey    (o_grey),
    .o_last_out(o_last_out)
);

/* sim/depth_sigma_normalizer_tb.sv */
// ----------------------------------------------------------------------------
// depth_sigma_normalizer_tb
// Drives accumulate and map passes of depth frames into the normalizer and
// checks every grey beat against a cycle-free model of the 3-sigma mapping.
// ----------------------------------------------------------------------------
module depth_sigma_normalizer_tb;
    import dsn_pkg::*;

    localparam int FRAC      = DEF_FRACTION_BITS;
    localparam int CAP_LOG2  = DEF_MAX_PIXELS_LOG2;
    localparam int IDLE_WAIT = 400;
    localparam int WATCHDOG  = 20000;

    typedef struct packed {
        logic        func;
        logic [31:0] bits;
        logic        last;
    } t_sample;

    typedef struct packed {
        logic [7:0] grey;
        logic       last;
    } t_grey;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_push = 1'b0;
    logic        i_func = 1'b0;
    logic [31:0] i_depth_bits = '0;
    logic        i_last = 1'b0;
    logic        i_pop = 1'b0;
    logic        o_full, o_empty, o_last_out;
    logic [7:0]  o_grey;

    depth_sigma_normalizer uut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Frame statistics held by the model.
    logic [63:0] acc_sum, acc_sq, acc_cnt, frame_mean, frame_scale;
    logic        frame_flat;

    t_sample pending_samples[$];
    t_grey   expected_greys[$];
    int      errors = 0;
    int      quiet_cycles = 0;
    bit      stimulus_done = 0;
    bit      hold_sender = 0;

    task automatic queue_sample(logic func, logic [31:0] bits, logic last);
        t_sample s;
        s = '{func, bits, last};
        pending_samples.insert(pending_samples.size(), s);
    endtask

    function automatic bit sample_counts(logic [31:0] b);
        return b != 32'd0 && b < ONE_BITS;
    endfunction

    function automatic logic [63:0] depth_fixed(logic [31:0] b);
        int          shift;
        logic [63:0] mant;
        mant = {41'd0, b[22:0]};
        if (b[30:23] == 8'd0) begin
            shift = 149 - FRAC;
        end else begin
            mant[23] = 1'b1;
            shift = 150 - int'(b[30:23]) - FRAC;
        end
        if (shift < 0 || shift >= 32) return 64'd0;
        return mant >> shift;
    endfunction

    function automatic logic [63:0] product_q32(logic [63:0] x);
        if (2 * FRAC >= 32) return x >> (2 * FRAC - 32);
        return x << (32 - 2 * FRAC);
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    task automatic derive_window();
        logic [63:0] msq, meansq, var_q, sigma, sc;
        frame_flat = 1'b1;
        frame_mean = 0;
        frame_scale = 0;
        if (acc_cnt == 0) return;
        frame_mean = acc_sum / acc_cnt;
        msq = acc_sq / acc_cnt;
        meansq = product_q32(frame_mean * frame_mean);
        var_q = msq > meansq ? msq - meansq : 64'd0;
        sigma = int_sqrt(var_q << 16);
        if (sigma == 0) begin
            frame_mean = 0;
            return;
        end
        sc = (64'd255 << 40) / (64'd3 * sigma);
        frame_scale = sc > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : sc;
        frame_flat = 1'b0;
    endtask

    function automatic logic [7:0] grey_of(logic [31:0] b);
        longint diff, acc;
        if (b == ONE_BITS) return GREY_MAX;
        if (!sample_counts(b)) return GREY_MIN;
        if (frame_flat) return GREY_MID;
        diff = longint'(depth_fixed(b)) - longint'(frame_mean);
        acc = diff * longint'(frame_scale) + longint'(64'd255 << (FRAC + 15));
        if (acc < 0) return GREY_MIN;
        acc = acc >>> (FRAC + 16);
        return acc > 255 ? GREY_MAX : acc[7:0];
    endfunction

    task automatic predict_sample(t_sample s);
        logic [63:0] q;
        t_grey       e;
        if (s.func == FUNC_ACC) begin
            if (sample_counts(s.bits) && acc_cnt < (64'd1 << CAP_LOG2)) begin
                q = depth_fixed(s.bits);
                acc_sum += q;
                acc_sq += product_q32(q * q);
                acc_cnt += 1;
            end
            if (s.last) derive_window();
        end else begin
            e = '{grey: grey_of(s.bits), last: s.last};
            expected_greys.insert(expected_greys.size(), e);
            if (s.last) begin
                acc_sum = 0;
                acc_sq = 0;
                acc_cnt = 0;
            end
        end
    endtask

    function automatic logic [31:0] random_depth();
        int pick;
        pick = $urandom_range(0, 19);
        case (pick)
            0: return 32'd0;
            1: return ONE_BITS;
            2: return $urandom();
            3: return $urandom_range(1, 32'h007F_FFFF);
            4: return 32'h8000_0000 | $urandom();
            5: return $urandom_range(32'h3F80_0001, 32'h7FFF_FFFF);
            default: return $urandom_range(32'h3E00_0000, 32'h3F7F_FFFF);
        endcase
    endfunction

    // Narrow frames give small sigma, wide ones give a broad spread.
    task automatic queue_frame(int n, bit narrow);
        logic [31:0] frame[$];
        logic [31:0] base;
        logic [31:0] d;
        base = $urandom_range(32'h3E00_0000, 32'h3F70_0000);
        for (int k = 0; k < n; k++) begin
            d = narrow && $urandom_range(0, 3) != 0
                ? base + $urandom_range(0, 255) : random_depth();
            frame.insert(frame.size(), d);
        end
        for (int k = 0; k < n; k++)
            queue_sample(FUNC_ACC, frame[k], k == n - 1);
        if ($urandom_range(0, 4) == 0)
            queue_sample(FUNC_ACC, random_depth(), 1'b1);
        for (int k = 0; k < n; k++)
            queue_sample(FUNC_MAP, frame[k], k == n - 1);
    endtask

    function automatic int gap_length();
        if ($urandom_range(0, 9) < 6) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    int send_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_push && !o_full) begin
                predict_sample('{i_func, i_depth_bits, i_last});
            end
            if (!(i_push && o_full)) begin
                if (send_gap > 0 || hold_sender || pending_samples.size() == 0) begin
                    i_push <= 1'b0;
                    if (send_gap > 0) send_gap <= send_gap - 1;
                end else begin
                    t_sample s;
                    s = pending_samples.pop_front();
                    i_push <= 1'b1;
                    i_func <= s.func;
                    i_depth_bits <= s.bits;
                    i_last <= s.last;
                    send_gap <= gap_length();
                end
            end
        end
    end

    int pop_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_pop && !o_empty) begin
                if (expected_greys.size() == 0) begin
                    $display("%0t: unexpected grey beat %0d last %0b",
                             $time, o_grey, o_last_out);
                    errors++;
                end else begin
                    t_grey e;
                    e = expected_greys.pop_front();
                    if (e.grey !== o_grey) begin
                        $display("%0t: grey expected %0d actual %0d", $time, e.grey, o_grey);
                        errors++;
                    end
                    if (e.last !== o_last_out) begin
                        $display("%0t: last expected %0b actual %0b",
                                 $time, e.last, o_last_out);
                        errors++;
                    end
                end
            end
            if (pop_gap > 0) begin
                i_pop <= 1'b0;
                pop_gap <= pop_gap - 1;
            end else begin
                i_pop <= 1'b1;
                pop_gap <= gap_length();
            end
            if ((i_push && !o_full) || (i_pop && !o_empty) || stimulus_done)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        logic [31:0] corner[$];
        acc_sum = 0; acc_sq = 0; acc_cnt = 0;
        frame_mean = 0; frame_scale = 0; frame_flat = 1'b1;
        // Map before any statistics, then a frame of corner samples.
        queue_sample(FUNC_MAP, 32'h3F00_0000, 1'b0);
        corner = '{32'h0000_0000, 32'h0000_0001, 32'h007F_FFFF, 32'h3F7F_FFFF, ONE_BITS,
                   32'h3F80_0001, 32'h7F80_0000, 32'h7FC0_0000, 32'hFFFF_FFFF,
                   32'h8000_0001, 32'h3E80_0000, 32'h3F40_0000};
        foreach (corner[k]) queue_sample(FUNC_ACC, corner[k], k == 11);
        foreach (corner[k]) queue_sample(FUNC_MAP, corner[k], k == 11);
        // Empty accumulate pass gives a flat frame.
        queue_sample(FUNC_ACC, 32'd0, 1'b1);
        queue_sample(FUNC_MAP, 32'h3F00_0000, 1'b1);
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_samples.size() == 0 && expected_greys.size() == 0);
        hold_sender = 1;
        for (int k = 0; k < 1500; ) begin
            int n;
            n = $urandom_range(0, 19) == 0 ? $urandom_range(40, 90) : $urandom_range(1, 12);
            queue_frame(n, $urandom_range(0, 2) == 0);
            k += 2 * n;
            hold_sender = 0;
            // Once in a while the sender waits for the receiver to drain.
            if ($urandom_range(0, 15) == 0) begin
                wait (pending_samples.size() == 0);
                @(posedge i_clk);
                hold_sender = 1;
                wait (expected_greys.size() == 0);
                hold_sender = 0;
            end
        end
        wait (pending_samples.size() == 0);
        @(posedge i_clk);
        wait (expected_greys.size() == 0);
        stimulus_done = 1;
        repeat (IDLE_WAIT) @(posedge i_clk);
        if (errors == 0 && expected_greys.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
